FILE: hw/rtl/ole_pkg.sv
// Package for the ordered list engine: command and status codes,
// transfer structs and the control bundle broadcast along the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  // wide enough for a position or a count at the largest supported capacity
  localparam int unsigned POS_W        = 11;
  localparam int unsigned VAL_W        = 32;

  localparam logic [3:0] CMD_INS_FIRST = 4'd0;
  localparam logic [3:0] CMD_INS_LAST  = 4'd1;
  localparam logic [3:0] CMD_INS_AT    = 4'd2;
  localparam logic [3:0] CMD_DEL_FIRST = 4'd3;
  localparam logic [3:0] CMD_DEL_LAST  = 4'd4;
  localparam logic [3:0] CMD_DEL_AT    = 4'd5;
  localparam logic [3:0] CMD_SEARCH    = 4'd6;
  localparam logic [3:0] CMD_SIZE      = 4'd7;
  localparam logic [3:0] CMD_CLEAR     = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [3:0]        cmd;
    logic signed [31:0] value;
    logic signed [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_position;
    logic [6:0] list_size;
  } out_item_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] at;
    logic [POS_W-1:0] limit;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/ole_cell.sv
// One list cell: holds a single entry, shifts with its neighbours on
// insert and delete, and flags a search match.
// Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_cell import ole_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val,
  output logic             hit
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (MY_POS > ctrl.at) begin
        val_nxt = left_val;
      end else if (MY_POS == ctrl.at) begin
        val_nxt = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (MY_POS >= ctrl.at) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  // only occupied cells may match
  assign hit = (val_r == ctrl.value) && (MY_POS < ctrl.limit);

endmodule

FILE: hw/rtl/ole_find.sv
// Registered priority tree: lowest index among the cell match flags.
// One tree level per cycle. Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_find import ole_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic [CAPACITY-1:0]           hit,
  output logic                          found_hit,
  output logic [$clog2(CAPACITY)-1:0]   found_idx
);

  localparam int unsigned IDXW   = $clog2(CAPACITY);
  localparam int unsigned LEAVES = 1 << IDXW;

  logic            t_hit [1:2*LEAVES-1];
  logic [IDXW-1:0] t_idx [1:2*LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < CAPACITY) begin : g_used
      logic hit_r;
      always_ff @(posedge clk) begin
        hit_r <= hit[i];
      end
      assign t_hit[LEAVES+i] = hit_r;
    end else begin : g_pad
      assign t_hit[LEAVES+i] = 1'b0;
    end
    assign t_idx[LEAVES+i] = IDXW'(i);
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic            hit_r;
    logic [IDXW-1:0] idx_r;
    always_ff @(posedge clk) begin
      hit_r <= t_hit[2*n] | t_hit[2*n+1];
      idx_r <= t_hit[2*n] ? t_idx[2*n] : t_idx[2*n+1];
    end
    assign t_hit[n] = hit_r;
    assign t_idx[n] = idx_r;
  end

  assign found_hit = t_hit[1];
  assign found_idx = t_idx[1];

endmodule

FILE: hw/rtl/ordered_list_engine.sv
// Ordered list engine: bounded list held in a chain of shifting cells.
// Every command but search: result strobed on the next cycle after
// acceptance; one command per cycle while not busy. Search: busy while
// the match tree settles, result registered from the settled tree root.
// Reset (synchronous, rst_n low) empties the list.
// Results cannot be held off; out_valid marks each for one cycle.
`timescale 1ns / 1ps

module ordered_list_engine import ole_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned IDXW = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned SW   = $clog2(IDXW + 2) + 1;
  localparam logic [SW-1:0] SRCH_LAT = SW'(IDXW + 1);
  localparam logic [SW-1:0] SRCH_ONE = SW'(1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  logic [CW-1:0]     count_r, count_nxt;
  logic [SW-1:0]     srch_r, srch_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  cell_ctrl_t        ctrl;
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic              found_hit;
  logic [IDXW-1:0]   found_idx;

  logic              accept;
  logic              neg;
  logic [POS_W-1:0]  pos_ext, cnt_ext;
  logic              full, empty;
  logic [2:0]        status;
  logic [CW+6:0]     size_wide;
  logic [IDXW+5:0]   found_wide;

  assign accept  = start && !busy;
  assign busy    = (srch_r != '0);
  assign neg     = in_item.position[7];
  assign pos_ext = POS_W'(in_item.position[6:0]);
  assign cnt_ext = POS_W'(count_r);
  assign full    = (count_r == CAP_CNT);
  assign empty   = (count_r == '0);

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.at    = '0;
    ctrl.limit = cnt_ext;
    ctrl.value = in_item.value;
    count_nxt  = count_r;
    status     = ST_OK;
    srch_nxt   = (srch_r != '0) ? srch_r - SRCH_ONE : srch_r;
    if (accept) begin
      unique case (in_item.cmd)
        CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
          if ((in_item.cmd == CMD_INS_AT) && neg) begin
            status = ST_INVALID;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CW'(1);
            if (in_item.cmd == CMD_INS_FIRST) begin
              ctrl.at = '0;
            end else if (in_item.cmd == CMD_INS_LAST || pos_ext > cnt_ext) begin
              ctrl.at = cnt_ext;
            end else begin
              ctrl.at = pos_ext;
            end
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.del  = 1'b1;
            ctrl.at   = (in_item.cmd == CMD_DEL_FIRST) ? '0 : cnt_ext - POS_W'(1);
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_DEL_AT: begin
          priority if (neg) begin
            status = ST_INVALID;
          end else if (empty) begin
            status = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            status = ST_INVALID;
          end else begin
            ctrl.del  = 1'b1;
            ctrl.at   = pos_ext;
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_SEARCH: begin
          srch_nxt = SRCH_LAT;
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  assign size_wide  = (CW + 7)'(count_nxt);
  assign found_wide = (IDXW + 6)'(found_idx);

  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (srch_r == SRCH_ONE) begin
      // search tree root is settled now
      out_valid_nxt               = 1'b1;
      out_item_nxt.status         = found_hit ? ST_OK : ST_NOT_FOUND;
      out_item_nxt.found_position = found_hit ? found_wide[5:0] : 6'd0;
      out_item_nxt.list_size      = size_wide[6:0];
    end else if (accept && in_item.cmd != CMD_SEARCH) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.status         = status;
      out_item_nxt.found_position = 6'd0;
      out_item_nxt.list_size      = size_wide[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      srch_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      srch_r      <= srch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lv, rv;
    if (i == 0) begin : g_head
      assign lv = cell_val[i];
    end else begin : g_mid_l
      assign lv = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rv = cell_val[i];
    end else begin : g_mid_r
      assign rv = cell_val[i+1];
    end
    ole_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (lv),
      .right_val (rv),
      .val       (cell_val[i]),
      .hit       (cell_hit[i])
    );
  end

  ole_find #(.CAPACITY(CAPACITY)) u_find (
    .clk       (clk),
    .hit       (cell_hit),
    .found_hit (found_hit),
    .found_idx (found_idx)
  );

endmodule
